@@ hw/rtl/offload_switch_policy_core_defines.svh @@
// ----------------------------------------------------------------------------
// Offload switch policy assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OFFLOAD_SWITCH_POLICY_CORE_DEFINES_SVH
`define OFFLOAD_SWITCH_POLICY_CORE_DEFINES_SVH

// Same-cycle implication.
`define OSP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/osp_pkg.sv @@
// ----------------------------------------------------------------------------
// Offload switch policy package
// Shared widths, codes, reset values and interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package osp_pkg;

    localparam int PORT_W           = 16;
    localparam int LIST_COUNT_W     = 4;
    localparam int THRESH_W         = 16;
    localparam int RATIO_W          = 8;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_INDEX_W      = 3;
    localparam int ENTRIES_PER_WORD = CFG_DATA_W / PORT_W;
    localparam int MAX_LIST_ENTRIES = 2 * ENTRIES_PER_WORD;

    localparam int DEF_COUNT_WIDTH  = 32;
    localparam int DEF_LIST_ENTRIES = MAX_LIST_ENTRIES;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1024;
    localparam logic [RATIO_W-1:0]  RATIO_RESET  = 8'd80;

    localparam logic [1:0] FAM_IPV4    = 2'd0;
    localparam logic [1:0] FAM_IPV6    = 2'd1;
    localparam logic [3:0] TYPE_STREAM = 4'd1;
    localparam logic [7:0] PROTO_IP    = 8'd0;
    localparam logic [7:0] PROTO_TCP   = 8'd6;

    typedef enum logic [2:0] {
        MODE_OFF_CONN  = 3'd0,
        MODE_OFF_SEND  = 3'd1,
        MODE_OFF_REL   = 3'd2,
        MODE_TCP_CONN  = 3'd3,
        MODE_TCP_RECV  = 3'd4,
        MODE_TCP_FIN   = 3'd5,
        MODE_LISTEN_RQ = 3'd6,
        MODE_CONN_RQ   = 3'd7
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLACK_LO   = 3'd0,
        CFG_BLACK_HI   = 3'd1,
        CFG_WHITE_LO   = 3'd2,
        CFG_WHITE_HI   = 3'd3,
        CFG_BLACK_CNT  = 3'd4,
        CFG_WHITE_CNT  = 3'd5,
        CFG_THRESHOLD  = 3'd6,
        CFG_SEND_RATIO = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [LIST_COUNT_W-1:0] black_count;
        logic [LIST_COUNT_W-1:0] white_count;
        logic [THRESH_W-1:0]     conn_threshold;
        logic [RATIO_W-1:0]      send_ratio;
    } cfg_t;

    typedef struct packed {
        logic enabled;       // flag before this transaction
        logic enabled_next;  // flag after this transaction
        logic flipped;
    } policy_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/offload_switch_policy_core.sv @@
// ----------------------------------------------------------------------------
// Offload switch policy core
// Event counting, offload mode switching and per-request accelerate decision.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transaction:
//   mode, port, family, sock_type, protocol. Every event yields exactly one
//   result transaction on the output channel (out_valid/out_ready):
//   accelerate, offload_on and mode_flipped.
//   Configuration is a separate write channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data); cfg_ready is always high. Write it only while the
//   block is idle.
//   Accept loads the input register, then the result register (out_valid).
//   Throughput: one transaction per cycle while out_ready is high.
//   Reset: offload on, all counters zero, lists empty, threshold 1024,
//   ratio 80; both pipeline registers empty.
//   Stall: while the result register holds an untaken result, the input
//   register still accepts one more transaction, then in_ready drops until
//   the receiver takes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "offload_switch_policy_core_defines.svh"

module offload_switch_policy_core #(
    parameter int COUNT_WIDTH  = osp_pkg::DEF_COUNT_WIDTH,
    parameter int LIST_ENTRIES = osp_pkg::DEF_LIST_ENTRIES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [osp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [osp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // event channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [2:0]                       mode,
    input  wire logic [osp_pkg::PORT_W-1:0]       port,
    input  wire logic [1:0]                       family,
    input  wire logic [3:0]                       sock_type,
    input  wire logic [7:0]                       protocol,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  accelerate,
    output logic                                  offload_on,
    output logic                                  mode_flipped
);
    import osp_pkg::*;

    cfg_t              cfg;
    logic [PORT_W-1:0] black_ports [LIST_ENTRIES];
    logic [PORT_W-1:0] white_ports [LIST_ENTRIES];

    // Input register stage
    logic              item_valid_reg;
    mode_t             mode_reg;
    logic [PORT_W-1:0] port_reg;
    logic [1:0]        family_reg;
    logic [3:0]        sock_type_reg;
    logic [7:0]        protocol_reg;

    // Result register stage
    logic out_valid_reg;
    logic accelerate_reg;
    logic offload_on_reg;
    logic flipped_reg;

    logic           in_fire;
    logic           step;
    logic           port_ok;
    logic           sock_ok;
    logic           is_request;
    logic           acc_next;
    policy_status_t status;

    assign cfg_ready = 1'b1;

    // The stored item moves into the result register whenever that register
    // is empty or being drained this cycle.
    assign step     = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    osp_cfg_regs #(
        .LIST_ENTRIES (LIST_ENTRIES)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (cfg_valid && cfg_ready),
        .wr_index    (cfg_index),
        .wr_data     (cfg_data),
        .cfg         (cfg),
        .black_ports (black_ports),
        .white_ports (white_ports)
    );

    osp_port_filter #(
        .LIST_ENTRIES (LIST_ENTRIES)
    ) u_filter (
        .port        (port_reg),
        .black_count (cfg.black_count),
        .white_count (cfg.white_count),
        .black_ports (black_ports),
        .white_ports (white_ports),
        .allowed     (port_ok)
    );

    osp_policy #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_policy (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .mode   (mode_reg),
        .cfg    (cfg),
        .status (status)
    );

    // Request decision: stream socket over IPv4/IPv6 with TCP or IP protocol;
    // connect requests additionally need offload on (flag before the event).
    assign is_request = (mode_reg == MODE_LISTEN_RQ) || (mode_reg == MODE_CONN_RQ);
    assign sock_ok    = ((family_reg == FAM_IPV4) || (family_reg == FAM_IPV6))
                     && (sock_type_reg == TYPE_STREAM)
                     && ((protocol_reg == PROTO_TCP) || (protocol_reg == PROTO_IP))
                     && !((mode_reg == MODE_CONN_RQ) && !status.enabled);
    assign acc_next   = is_request && sock_ok && port_ok;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk) begin
        if (in_fire)
        begin
            mode_reg      <= mode_t'(mode);
            port_reg      <= port;
            family_reg    <= family;
            sock_type_reg <= sock_type;
            protocol_reg  <= protocol;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (step)
        begin
            accelerate_reg <= acc_next;
            offload_on_reg <= status.enabled_next;
            flipped_reg    <= status.flipped;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accelerate   = accelerate_reg;
    assign offload_on   = offload_on_reg;
    assign mode_flipped = flipped_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Only a release or fin transaction can change the offload flag.
    `OSP_ASSERT_IMPLIES(a_flip_only_on_check, step && status.flipped,
        (mode_reg == MODE_OFF_REL) || (mode_reg == MODE_TCP_FIN),
        "offload flag changed on a non-check event")
    // Counter events never request acceleration.
    `OSP_ASSERT_IMPLIES(a_acc_only_request, step && acc_next,
        (mode_reg == MODE_LISTEN_RQ) || (mode_reg == MODE_CONN_RQ),
        "accelerate set on a counter event")
    // A held item is not dropped while the result side stalls.
    `OSP_ASSERT_NEXT(a_item_kept, item_valid_reg && !step, item_valid_reg,
        "held transaction lost during stall")
    // A stalled result keeps its flag value.
    `OSP_ASSERT_NEXT(a_result_held, out_valid_reg && !out_ready,
        out_valid_reg && $stable(offload_on_reg) && $stable(flipped_reg),
        "stalled result changed")

endmodule

`default_nettype wire

@@ hw/rtl/osp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Offload switch policy configuration registers
// Port lists, list counts, threshold and send ratio.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osp_cfg_regs #(
    parameter int LIST_ENTRIES = osp_pkg::DEF_LIST_ENTRIES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [osp_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  wire logic [osp_pkg::CFG_DATA_W-1:0]   wr_data,
    output osp_pkg::cfg_t                         cfg,
    output logic [osp_pkg::PORT_W-1:0]            black_ports [LIST_ENTRIES],
    output logic [osp_pkg::PORT_W-1:0]            white_ports [LIST_ENTRIES]
);
    import osp_pkg::*;

    cfg_idx_t wr_idx;
    cfg_t     cfg_reg;

    assign wr_idx = cfg_idx_t'(wr_index);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cfg_reg.black_count    <= '0;
            cfg_reg.white_count    <= '0;
            cfg_reg.conn_threshold <= THRESH_RESET;
            cfg_reg.send_ratio     <= RATIO_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                CFG_BLACK_CNT:  cfg_reg.black_count    <= wr_data[LIST_COUNT_W-1:0];
                CFG_WHITE_CNT:  cfg_reg.white_count    <= wr_data[LIST_COUNT_W-1:0];
                CFG_THRESHOLD:  cfg_reg.conn_threshold <= wr_data[THRESH_W-1:0];
                CFG_SEND_RATIO: cfg_reg.send_ratio     <= wr_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // Every list entry is stored; entry i sits in the lo or hi word.
    for (genvar i = 0; i < LIST_ENTRIES; i++) begin : g_entry
        localparam cfg_idx_t BLACK_IDX = (i < ENTRIES_PER_WORD) ? CFG_BLACK_LO : CFG_BLACK_HI;
        localparam cfg_idx_t WHITE_IDX = (i < ENTRIES_PER_WORD) ? CFG_WHITE_LO : CFG_WHITE_HI;
        localparam int       SHIFT     = PORT_W * (i % ENTRIES_PER_WORD);

        logic [PORT_W-1:0] black_reg;
        logic [PORT_W-1:0] white_reg;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
            begin
                black_reg <= '0;
                white_reg <= '0;
            end
            else if (wr_en)
            begin
                if (wr_idx == BLACK_IDX)
                begin
                    black_reg <= wr_data[SHIFT +: PORT_W];
                end
                if (wr_idx == WHITE_IDX)
                begin
                    white_reg <= wr_data[SHIFT +: PORT_W];
                end
            end
        end

        assign black_ports[i] = black_reg;
        assign white_ports[i] = white_reg;
    end

endmodule

`default_nettype wire

@@ hw/rtl/osp_port_filter.sv @@
// ----------------------------------------------------------------------------
// Offload switch policy port filter
// Parallel blacklist / whitelist match on one port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osp_port_filter #(
    parameter int LIST_ENTRIES = osp_pkg::DEF_LIST_ENTRIES
) (
    input  wire logic [osp_pkg::PORT_W-1:0]        port,
    input  wire logic [osp_pkg::LIST_COUNT_W-1:0]  black_count,
    input  wire logic [osp_pkg::LIST_COUNT_W-1:0]  white_count,
    input  wire logic [osp_pkg::PORT_W-1:0]        black_ports [LIST_ENTRIES],
    input  wire logic [osp_pkg::PORT_W-1:0]        white_ports [LIST_ENTRIES],
    output logic                                   allowed
);
    import osp_pkg::*;

    logic [LIST_ENTRIES-1:0] black_hit;
    logic [LIST_ENTRIES-1:0] white_hit;

    // Count above LIST_ENTRIES simply enables every stored entry.
    for (genvar i = 0; i < LIST_ENTRIES; i++) begin : g_cmp
        localparam logic [LIST_COUNT_W-1:0] IDX = LIST_COUNT_W'(i);
        assign black_hit[i] = (IDX < black_count) && (black_ports[i] == port);
        assign white_hit[i] = (IDX < white_count) && (white_ports[i] == port);
    end

    always_comb begin
        if (black_count != '0)
        begin
            allowed = ~(|black_hit);
        end
        else if (white_count != '0)
        begin
            allowed = |white_hit;
        end
        else
        begin
            allowed = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/osp_policy.sv @@
// ----------------------------------------------------------------------------
// Offload switch policy counters and mode flag
// Saturating event counters, threshold check and ratio compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osp_policy #(
    parameter int COUNT_WIDTH = osp_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire osp_pkg::mode_t          mode,
    input  wire osp_pkg::cfg_t           cfg,
    output osp_pkg::policy_status_t      status
);
    import osp_pkg::*;

    localparam int PW = COUNT_WIDTH + RATIO_W;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    logic                   enabled_reg,  enabled_next;
    logic [COUNT_WIDTH-1:0] off_conn_reg, off_conn_next;
    logic [COUNT_WIDTH-1:0] off_send_reg, off_send_next;
    logic [COUNT_WIDTH-1:0] off_rel_reg,  off_rel_next;
    logic [COUNT_WIDTH-1:0] pl_conn_reg,  pl_conn_next;
    logic [COUNT_WIDTH-1:0] pl_recv_reg,  pl_recv_next;
    logic [COUNT_WIDTH-1:0] pl_fin_reg,   pl_fin_next;

    logic [COUNT_WIDTH-1:0] rel_inc, fin_inc, thr_ext, mul_conn, half;
    logic [PW-1:0]          product, half_ext;

    assign rel_inc  = sat_inc(off_rel_reg);
    assign fin_inc  = sat_inc(pl_fin_reg);
    assign thr_ext  = COUNT_WIDTH'(cfg.conn_threshold);

    // One multiplier shared by the release and fin checks.
    assign mul_conn = (mode == MODE_OFF_REL) ? off_conn_reg : pl_conn_reg;
    assign half     = (mode == MODE_OFF_REL) ? (off_send_reg >> 1) : (pl_recv_reg >> 1);
    assign product  = PW'(mul_conn) * PW'(cfg.send_ratio);
    assign half_ext = PW'(half);

    always_comb begin
        enabled_next  = enabled_reg;
        off_conn_next = off_conn_reg;
        off_send_next = off_send_reg;
        off_rel_next  = off_rel_reg;
        pl_conn_next  = pl_conn_reg;
        pl_recv_next  = pl_recv_reg;
        pl_fin_next   = pl_fin_reg;
        if (step)
        begin
            case (mode)
                MODE_OFF_CONN:
                begin
                    if (enabled_reg) off_conn_next = sat_inc(off_conn_reg);
                end
                MODE_OFF_SEND:
                begin
                    if (enabled_reg) off_send_next = sat_inc(off_send_reg);
                end
                MODE_OFF_REL:
                begin
                    if (enabled_reg)
                    begin
                        off_rel_next = rel_inc;
                        if ((off_conn_reg > thr_ext) && (rel_inc >= thr_ext))
                        begin
                            if (product > half_ext) enabled_next = 1'b0;
                            off_conn_next = '0;
                            off_send_next = '0;
                            off_rel_next  = '0;
                        end
                    end
                end
                MODE_TCP_CONN:
                begin
                    if (!enabled_reg) pl_conn_next = sat_inc(pl_conn_reg);
                end
                MODE_TCP_RECV:
                begin
                    if (!enabled_reg) pl_recv_next = sat_inc(pl_recv_reg);
                end
                MODE_TCP_FIN:
                begin
                    if (!enabled_reg)
                    begin
                        pl_fin_next = fin_inc;
                        if ((pl_conn_reg > thr_ext) && (fin_inc >= thr_ext))
                        begin
                            if (product < half_ext) enabled_next = 1'b1;
                            pl_conn_next = '0;
                            pl_recv_next = '0;
                            pl_fin_next  = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b1;
            off_conn_reg <= '0;
            off_send_reg <= '0;
            off_rel_reg  <= '0;
            pl_conn_reg  <= '0;
            pl_recv_reg  <= '0;
            pl_fin_reg   <= '0;
        end
        else
        begin
            enabled_reg  <= enabled_next;
            off_conn_reg <= off_conn_next;
            off_send_reg <= off_send_next;
            off_rel_reg  <= off_rel_next;
            pl_conn_reg  <= pl_conn_next;
            pl_recv_reg  <= pl_recv_next;
            pl_fin_reg   <= pl_fin_next;
        end
    end

    assign status.enabled      = enabled_reg;
    assign status.enabled_next = enabled_next;
    assign status.flipped      = enabled_next != enabled_reg;

endmodule

`default_nettype wire
